[design/sttm_pkg.sv]
// Package for the single-target track manager.
// Commands, configuration register indexes, and the shared configuration record type.
package sttm_pkg;

  localparam int unsigned CmdBits   = 2;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned DistBits  = 15;
  localparam int unsigned ScoreBits = 16;
  localparam int unsigned ClassBits = 8;
  localparam int unsigned MissBits  = 7;
  localparam int unsigned CntBits   = 32;
  localparam int unsigned InvalidMisses = 100;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_DETECT = 2'd1,
    CMD_END    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_WIDTH_LIMIT  = 3'd2,
    CFG_HEIGHT_LIMIT = 3'd3,
    CFG_SCORE_THRESH = 3'd4,
    CFG_MISS_LIMIT   = 3'd5,
    CFG_PREF_CLASS   = 3'd6,
    CFG_UNUSED       = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [11:0] image_width;
    logic [11:0] image_height;
    logic [11:0] width_limit;
    logic [11:0] height_limit;
    logic [15:0] score_threshold;
    logic [6:0]  miss_limit;
    logic [7:0]  preferred_class;
  } cfg_t;

endpackage

[design/sttm_front.sv]
// Front end: takes input transfers, computes the center distance for each one
// and registers it with the transfer fields. Depends on sttm_pkg.
module sttm_front import sttm_pkg::*; #(
  parameter int unsigned CoordBits = 13
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [CmdBits-1:0]          in_command,
  input  logic signed [CoordBits-1:0] in_left,
  input  logic signed [CoordBits-1:0] in_top,
  input  logic signed [CoordBits-1:0] in_box_width,
  input  logic signed [CoordBits-1:0] in_box_height,
  input  logic [ScoreBits-1:0]        in_score,
  input  logic [ClassBits-1:0]        in_class_id,
  input  cfg_t                        cfg,
  output logic                        q_valid,
  input  logic                        q_ready,
  output logic [CmdBits-1:0]          q_cmd,
  output logic signed [CoordBits-1:0] q_l,
  output logic signed [CoordBits-1:0] q_t,
  output logic signed [CoordBits-1:0] q_w,
  output logic signed [CoordBits-1:0] q_h,
  output logic [ScoreBits-1:0]        q_score,
  output logic [ClassBits-1:0]        q_cls,
  output logic [CoordBits+3:0]        q_dist
);
  localparam int unsigned DW = CoordBits + 4;

  logic               v_r;
  logic [CmdBits-1:0] cmd_r;
  logic signed [CoordBits-1:0] l_r, t_r, w_r, h_r;
  logic [ScoreBits-1:0] s_r;
  logic [ClassBits-1:0] c_r;
  logic [DW-1:0]        d_r;
  logic signed [DW:0]   dx, dy;
  logic [DW-1:0]        dist_nxt;
  logic                 take;

  assign in_ready = !v_r || q_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    dx = ((DW+1)'(in_left) <<< 1) + (DW+1)'(in_box_width)
       - (DW+1)'(signed'({1'b0, cfg.image_width}));
    dy = ((DW+1)'(in_top) <<< 1) + (DW+1)'(in_box_height)
       - (DW+1)'(signed'({1'b0, cfg.image_height}));
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    dist_nxt = DW'(dx) + DW'(dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (take) begin
      cmd_r <= in_command;
      l_r <= in_left;
      t_r <= in_top;
      w_r <= in_box_width;
      h_r <= in_box_height;
      s_r <= in_score;
      c_r <= in_class_id;
      d_r <= dist_nxt;
    end
  end

  assign q_valid = v_r;
  assign q_cmd   = cmd_r;
  assign q_l = l_r;
  assign q_t = t_r;
  assign q_w = w_r;
  assign q_h = h_r;
  assign q_score = s_r;
  assign q_cls = c_r;
  assign q_dist = d_r;
endmodule

[design/sttm_back.sv]
// Back end: frame accumulators, match test, track state and result register.
// Depends on sttm_pkg.
module sttm_back import sttm_pkg::*; #(
  parameter int unsigned CoordBits = 13
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cfg_t                        cfg,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  logic [CmdBits-1:0]          q_cmd,
  input  logic signed [CoordBits-1:0] q_l,
  input  logic signed [CoordBits-1:0] q_t,
  input  logic signed [CoordBits-1:0] q_w,
  input  logic signed [CoordBits-1:0] q_h,
  input  logic [ScoreBits-1:0]        q_score,
  input  logic [ClassBits-1:0]        q_cls,
  input  logic [CoordBits+3:0]        q_dist,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_tracking,
  output logic signed [CoordBits-1:0] out_left,
  output logic signed [CoordBits-1:0] out_top,
  output logic signed [CoordBits:0]   out_right,
  output logic signed [CoordBits:0]   out_bottom,
  output logic [ScoreBits-1:0]        out_score,
  output logic [ClassBits-1:0]        out_class,
  output logic [CntBits-1:0]          out_track_age,
  output logic [CntBits-1:0]          out_track_number,
  output logic [MissBits-1:0]         out_miss_count
);
  localparam int unsigned DW = CoordBits + 4;
  localparam int unsigned AW = 2 * CoordBits + 4;
  localparam int unsigned CB = CoordBits;

  // The distance is at most about 4*2^CB, below 2^(CB+3); all-ones is the empty mark.
  logic [DW-1:0] any_d_r, pref_d_r;
  logic signed [CB-1:0] al_r, at_r, aw_r, ah_r, pl_r, pt_r, pw_r, ph_r;
  logic [ScoreBits-1:0] as_r, ps_r;
  logic [ClassBits-1:0] ac_r, pc_r;
  logic seen_r, match_r, pref_r;
  logic signed [CB-1:0] tl_r, tt_r, tw_r, th_r;
  logic [ScoreBits-1:0] ts_r;
  logic trk_r;
  logic [MissBits-1:0] miss_r;
  logic [CntBits-1:0] age_r, num_r;
  logic [ClassBits-1:0] cls_r;
  logic ov_r;

  logic go, is_det, is_end, is_start, upd_any, upd_pref, match;
  logic signed [CB+1:0] x0, x1, y0, y1, iw, ih;
  logic signed [AW-1:0] inter3, area_sum;

  assign q_ready  = !ov_r || out_ready;
  assign go       = q_valid && q_ready;
  assign is_start = go && (q_cmd == CMD_START);
  assign is_det   = go && (q_cmd == CMD_DETECT);
  assign is_end   = go && (q_cmd == CMD_END);
  assign upd_any  = is_det && (q_dist < any_d_r);
  assign upd_pref = is_det && (q_cls == cfg.preferred_class) && (q_dist < pref_d_r);

  always_comb begin
    x0 = ((CB+2)'(tl_r) > (CB+2)'(q_l)) ? (CB+2)'(tl_r) : (CB+2)'(q_l);
    y0 = ((CB+2)'(tt_r) > (CB+2)'(q_t)) ? (CB+2)'(tt_r) : (CB+2)'(q_t);
    x1 = ((CB+2)'(tl_r) + (CB+2)'(tw_r) < (CB+2)'(q_l) + (CB+2)'(q_w))
       ? (CB+2)'(tl_r) + (CB+2)'(tw_r) : (CB+2)'(q_l) + (CB+2)'(q_w);
    y1 = ((CB+2)'(tt_r) + (CB+2)'(th_r) < (CB+2)'(q_t) + (CB+2)'(q_h))
       ? (CB+2)'(tt_r) + (CB+2)'(th_r) : (CB+2)'(q_t) + (CB+2)'(q_h);
    iw = x1 - x0;
    ih = y1 - y0;
    inter3 = AW'(3) * AW'(iw) * AW'(ih);
    area_sum = AW'(tw_r) * AW'(th_r) + AW'(q_w) * AW'(q_h);
    match = (iw > 0) && (ih > 0) && (inter3 > area_sum);
  end

  logic invalid, ok, bad;
  logic [MissBits-1:0] miss_upd;
  logic drop;
  logic use_pref;

  always_comb begin
    invalid = (ts_r == '0) || (tw_r <= 0) || (th_r <= 0);
    ok = !seen_r || match_r;
    bad = (ts_r < cfg.score_threshold) || !ok
        || ((CB+1)'(tw_r) > (CB+1)'(signed'({1'b0, cfg.width_limit})))
        || ((CB+1)'(th_r) > (CB+1)'(signed'({1'b0, cfg.height_limit})));
    if (invalid) miss_upd = MissBits'(InvalidMisses);
    else if (bad) miss_upd = (miss_r == '1) ? miss_r : miss_r + 1'b1;
    else miss_upd = '0;
    drop = miss_upd > cfg.miss_limit;
    use_pref = pref_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_d_r <= '1; pref_d_r <= '1;
      seen_r <= 1'b0; match_r <= 1'b0; pref_r <= 1'b0;
      tl_r <= '0; tt_r <= '0; tw_r <= '0; th_r <= '0; ts_r <= '0;
      trk_r <= 1'b0; miss_r <= '0; age_r <= '0; num_r <= '0; cls_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (out_ready) ov_r <= 1'b0;
      if (is_start || is_end) begin
        any_d_r <= '1; pref_d_r <= '1;
        seen_r <= 1'b0; match_r <= 1'b0; pref_r <= 1'b0;
      end
      if (is_start) begin
        tl_r <= q_l; tt_r <= q_t; tw_r <= q_w; th_r <= q_h; ts_r <= q_score;
      end
      if (is_det) begin
        seen_r <= 1'b1;
        if (match) match_r <= 1'b1;
        if (upd_any) any_d_r <= q_dist;
        if (upd_pref) begin
          pref_d_r <= q_dist;
          pref_r <= 1'b1;
        end
      end
      if (is_end) begin
        ov_r <= 1'b1;
        if (!trk_r) begin
          if (seen_r) begin
            trk_r <= 1'b1;
            cls_r <= use_pref ? pc_r : ac_r;
            age_r <= age_r + 1'b1;
          end
        end else if (drop) begin
          trk_r <= 1'b0; age_r <= '0; num_r <= num_r + 1'b1; miss_r <= '0;
        end else begin
          miss_r <= miss_upd;
          age_r <= age_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_any) begin
      al_r <= q_l; at_r <= q_t; aw_r <= q_w; ah_r <= q_h; as_r <= q_score; ac_r <= q_cls;
    end
    if (upd_pref) begin
      pl_r <= q_l; pt_r <= q_t; pw_r <= q_w; ph_r <= q_h; ps_r <= q_score; pc_r <= q_cls;
    end
    if (is_end) begin
      out_tracking <= 1'b0;
      out_left <= '0; out_top <= '0; out_right <= '0; out_bottom <= '0;
      out_score <= '0; out_class <= '0; out_track_age <= '0;
      out_track_number <= '0; out_miss_count <= '0;
      if (!trk_r) begin
        if (seen_r) begin
          out_tracking <= 1'b1;
          out_left   <= use_pref ? pl_r : al_r;
          out_top    <= use_pref ? pt_r : at_r;
          out_right  <= use_pref ? (CB+1)'(pl_r) + (CB+1)'(pw_r)
                                 : (CB+1)'(al_r) + (CB+1)'(aw_r);
          out_bottom <= use_pref ? (CB+1)'(pt_r) + (CB+1)'(ph_r)
                                 : (CB+1)'(at_r) + (CB+1)'(ah_r);
          out_score  <= use_pref ? ps_r : as_r;
          out_class  <= use_pref ? pc_r : ac_r;
          out_track_age <= age_r;
          out_track_number <= num_r;
          out_miss_count <= miss_r;
        end
      end else if (!drop) begin
        out_tracking <= 1'b1;
        out_left <= tl_r; out_top <= tt_r;
        out_right <= (CB+1)'(tl_r) + (CB+1)'(tw_r);
        out_bottom <= (CB+1)'(tt_r) + (CB+1)'(th_r);
        out_score <= ts_r; out_class <= cls_r;
        out_track_age <= age_r; out_track_number <= num_r;
        out_miss_count <= miss_upd;
      end
    end
  end

  assign out_valid = ov_r;

  a_miss_range: assert property (@(posedge clk) disable iff (!rst_n)
    trk_r |-> (miss_r <= cfg.miss_limit || $past(go) == 1'b0 || miss_r <= MissBits'(127)))
    else $error("miss count out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result lost under stall");
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    is_end |=> out_valid)
    else $error("frame end gave no result");
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (is_end && trk_r && drop) |=> (!out_tracking && !trk_r))
    else $error("dropped track reported");
endmodule

[design/single_target_track_manager.sv]
// Top level of the single-target track manager: config registers, front and back.
// A frame-end transfer passes through the front register and then the result register.
// Throughput: one item per cycle; the front register and the result register
// each stall on their own handshake.
// Reset (rst_n low, synchronous) restores register defaults and clears all track state.
module single_target_track_manager import sttm_pkg::*; #(
  parameter int unsigned COORD_BITS = 13
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [CmdBits-1:0]           in_command,
  input  logic signed [COORD_BITS-1:0] in_left,
  input  logic signed [COORD_BITS-1:0] in_top,
  input  logic signed [COORD_BITS-1:0] in_box_width,
  input  logic signed [COORD_BITS-1:0] in_box_height,
  input  logic [ScoreBits-1:0]         in_score,
  input  logic [ClassBits-1:0]         in_class_id,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_tracking,
  output logic signed [COORD_BITS-1:0] out_left,
  output logic signed [COORD_BITS-1:0] out_top,
  output logic signed [COORD_BITS:0]   out_right,
  output logic signed [COORD_BITS:0]   out_bottom,
  output logic [ScoreBits-1:0]         out_score,
  output logic [ClassBits-1:0]         out_class,
  output logic [CntBits-1:0]           out_track_age,
  output logic [CntBits-1:0]           out_track_number,
  output logic [MissBits-1:0]          out_miss_count,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CfgIdxBits-1:0]        cfg_index,
  input  logic [15:0]                  cfg_data
);
  cfg_t cfg_r;

  logic                         q_valid, q_ready;
  logic [CmdBits-1:0]           q_cmd;
  logic signed [COORD_BITS-1:0] q_l, q_t, q_w, q_h;
  logic [ScoreBits-1:0]         q_score;
  logic [ClassBits-1:0]         q_cls;
  logic [COORD_BITS+3:0]        q_dist;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{image_width: 12'd1920, image_height: 12'd1080, width_limit: 12'd576,
                 height_limit: 12'd324, score_threshold: 16'd19661, miss_limit: 7'd10,
                 preferred_class: 8'd1};
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  cfg_r.image_width <= cfg_data[11:0];
        CFG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data[11:0];
        CFG_WIDTH_LIMIT:  cfg_r.width_limit <= cfg_data[11:0];
        CFG_HEIGHT_LIMIT: cfg_r.height_limit <= cfg_data[11:0];
        CFG_SCORE_THRESH: cfg_r.score_threshold <= cfg_data;
        CFG_MISS_LIMIT:   cfg_r.miss_limit <= cfg_data[6:0];
        CFG_PREF_CLASS:   cfg_r.preferred_class <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  sttm_front #(.CoordBits(COORD_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_left, .in_top,
    .in_box_width, .in_box_height, .in_score, .in_class_id, .cfg(cfg_r),
    .q_valid, .q_ready, .q_cmd, .q_l, .q_t, .q_w, .q_h, .q_score, .q_cls, .q_dist
  );

  sttm_back #(.CoordBits(COORD_BITS)) u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_valid, .q_ready, .q_cmd, .q_l, .q_t, .q_w, .q_h,
    .q_score, .q_cls, .q_dist, .out_valid, .out_ready, .out_tracking, .out_left,
    .out_top, .out_right, .out_bottom, .out_score, .out_class, .out_track_age,
    .out_track_number, .out_miss_count
  );
endmodule
